FILE: rtl/assert_macros.svh
// Assertion macros shared by the display driver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/mddd_pkg.sv
// Types, register map and segment decode for the display driver.
package mddd_pkg;

    localparam int APB_ADDR_W   = 3;
    localparam int REG_IDX_BIT  = 2;

    // Register indexes
    localparam logic REG_DIGIT_COUNT = 1'b0;
    localparam logic REG_DWELL_TICKS = 1'b1;

    localparam logic [2:0]  DIGIT_COUNT_RST = 3'd6;
    localparam logic [15:0] DWELL_TICKS_RST = 16'd1000;

    localparam logic [7:0]  SEL_ALL_OFF = 8'hFF;

    // Exact floor(v / 10) for any v below 2**32: (v * RECIP_10) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [2:0]  digit_count;
        logic [15:0] dwell_ticks;
    } cfg_t;

    // Active-low gfedcba pattern; codes above nine fold back modulo ten.
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0, 4'd10: seg = 7'h40;
            4'd1, 4'd11: seg = 7'h79;
            4'd2, 4'd12: seg = 7'h24;
            4'd3, 4'd13: seg = 7'h30;
            4'd4, 4'd14: seg = 7'h19;
            4'd5, 4'd15: seg = 7'h12;
            4'd6:        seg = 7'h02;
            4'd7:        seg = 7'h78;
            4'd8:        seg = 7'h00;
            default:     seg = 7'h10;
        endcase
        return seg;
    endfunction

endpackage

FILE: rtl/mddd_if.sv
// Stream interfaces for display driver items and results.
interface mddd_in_if #(parameter int VALUE_WIDTH = 24);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface mddd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] segments;
    logic [7:0] digit_select;

    modport source (output valid, segments, digit_select, input ready);
    modport sink   (input valid, segments, digit_select, output ready);
endinterface

FILE: rtl/mddd_cfg.sv
// APB register block holding digit count and dwell time.
module mddd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mddd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output mddd_pkg::cfg_t                  cfg
);
    import mddd_pkg::*;

    logic [2:0]  digit_count_reg;
    logic [15:0] dwell_ticks_reg;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[REG_IDX_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= DIGIT_COUNT_RST;
            dwell_ticks_reg <= DWELL_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DIGIT_COUNT: digit_count_reg <= pwdata[2:0];
                REG_DWELL_TICKS: dwell_ticks_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DIGIT_COUNT: prdata = {29'd0, digit_count_reg};
            REG_DWELL_TICKS: prdata = {16'd0, dwell_ticks_reg};
        endcase
    end

    assign cfg.digit_count = digit_count_reg;
    assign cfg.dwell_ticks = dwell_ticks_reg;

endmodule

FILE: rtl/mddd_div10.sv
// Shared divide-by-ten unit: registered reciprocal multiply, then quotient and remainder.
module mddd_div10 #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [VALUE_WIDTH-1:0] dividend,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [3:0]             remainder
);
    import mddd_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + 32;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    logic [PROD_W-1:0]      prod_reg;
    logic [VALUE_WIDTH-1:0] dividend_reg;
    logic [VALUE_WIDTH-1:0] times_ten;

    // Capture the product and the operand together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= PROD_W'(dividend) * PROD_W'(RECIP_10);
            dividend_reg <= dividend;
        end
    end

    assign quotient  = VALUE_WIDTH'(prod_reg[PROD_W-1:RECIP_SHIFT]);
    assign times_ten = (quotient << 3) + (quotient << 1);
    assign remainder = 4'(dividend_reg - times_ten);

    // QUOT_W is the quotient's natural width; it must leave room for it
    if (QUOT_W < 1)
    begin : g_bad_width
        $error("VALUE_WIDTH too small for the divide-by-ten unit");
    end

endmodule

FILE: rtl/multiplexed_decimal_display_driver_core.sv
// Top level of the multiplexed seven-segment display driver.
// Tick item: goes to ST_EMIT, which registers the result once the output slot is free, then back to ST_IDLE.
// Load item: an ST_MUL multiply and an ST_SPLIT split per digit of the effective digit count
// through the shared divide-by-ten unit, then ST_EMIT to register the result.
// The input is not ready while an item is in work or its result waits for the output slot.
// Reset (async, active low): digits zero, scan at digit 0 lit, count 6, dwell 1000.
`include "assert_macros.svh"

module multiplexed_decimal_display_driver_core #(
    parameter int MAX_DIGITS  = 7,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mddd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    mddd_in_if.sink                         cmd,
    mddd_out_if.source                      disp
);
    import mddd_pkg::*;

    localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [3:0] MAX_CNT  = 4'(MAX_DIGITS);
    localparam logic [2:0] LAST_SEL = 3'(MAX_DIGITS - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    cfg_t cfg;

    logic [1:0]             state_reg, state_next;
    logic [POS_W-1:0]       idx_reg;
    logic [VALUE_WIDTH-1:0] work_reg;
    logic [3:0]             store_reg [MAX_DIGITS];
    logic [POS_W-1:0]       scan_pos_reg;
    logic [15:0]            dwell_cnt_reg;
    logic                   blank_reg;
    logic                   out_valid_reg;
    logic [6:0]             seg_reg;
    logic [7:0]             sel_reg;

    logic                   accept;
    logic                   tick_accept;
    logic                   load_accept;
    logic                   emit_fire;
    logic [3:0]             cnt_raw;
    logic [3:0]             eff_cnt;
    logic [15:0]            eff_dwell;
    logic [16:0]            dwell_inc;
    logic                   dwell_done;
    logic                   pos_wrap;
    logic                   last_digit;
    logic [2:0]             sel_idx;
    logic [VALUE_WIDTH-1:0] quot;
    logic [3:0]             rem;

    mddd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // One digit per pass: multiply in ST_MUL, quotient and remainder used in ST_SPLIT
    mddd_div10 #(.VALUE_WIDTH(VALUE_WIDTH)) u_div10 (
        .clk       (clk),
        .en        (state_reg == ST_MUL),
        .dividend  (work_reg),
        .quotient  (quot),
        .remainder (rem)
    );

    // Handshake: take a beat only when the sequencer is free
    assign cmd.ready   = (state_reg == ST_IDLE);
    assign accept      = cmd.valid && cmd.ready;
    assign tick_accept = accept && cmd.action;
    assign load_accept = accept && !cmd.action;

    // The result register frees up either empty or being drained this cycle
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || disp.ready);

    // Effective digit count: zero reads as one, anything past the store saturates
    assign cnt_raw = {1'b0, cfg.digit_count};
    always_comb
    begin
        priority if (cnt_raw == 4'd0)
            eff_cnt = 4'd1;
        else if (cnt_raw > MAX_CNT)
            eff_cnt = MAX_CNT;
        else
            eff_cnt = cnt_raw;
    end

    // Effective dwell: zero reads as one tick
    assign eff_dwell  = (cfg.dwell_ticks == 16'd0) ? 16'd1 : cfg.dwell_ticks;
    assign dwell_inc  = {1'b0, dwell_cnt_reg} + 17'd1;
    assign dwell_done = dwell_inc >= {1'b0, eff_dwell};

    // A position left beyond a lowered count still wraps on its next advance
    assign pos_wrap   = (4'(scan_pos_reg) + 4'd1) >= eff_cnt;
    assign last_digit = (4'(idx_reg) + 4'd1) >= eff_cnt;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_accept)
                    state_next = ST_MUL;
                else if (tick_accept)
                    state_next = ST_EMIT;
            end
            ST_MUL:   state_next = ST_SPLIT;
            ST_SPLIT: state_next = last_digit ? ST_EMIT : ST_MUL;
            ST_EMIT:  state_next = emit_fire ? ST_IDLE : ST_EMIT;
        endcase
    end

    // Control, scan timing and the digit store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            scan_pos_reg  <= '0;
            dwell_cnt_reg <= '0;
            blank_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                store_reg[i] <= 4'd0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (load_accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SPLIT)
            begin
                // Write the low digit, advance unless this was the last one kept
                store_reg[idx_reg] <= rem;
                if (!last_digit)
                    idx_reg <= idx_reg + POS_W'(1);
            end

            // Tick: leave blanking for the next digit, or count dwell toward blanking
            if (tick_accept)
            begin
                if (blank_reg)
                begin
                    blank_reg     <= 1'b0;
                    dwell_cnt_reg <= '0;
                    scan_pos_reg  <= pos_wrap ? '0 : scan_pos_reg + POS_W'(1);
                end
                else if (dwell_done)
                begin
                    blank_reg     <= 1'b1;
                    dwell_cnt_reg <= '0;
                end
                else
                begin
                    dwell_cnt_reg <= dwell_inc[15:0];
                end
            end

            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (disp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Anode of position p sits on select bit MAX_DIGITS-1-p
    assign sel_idx = LAST_SEL - 3'(scan_pos_reg);

    // Payload: running quotient and the registered result
    always_ff @(posedge clk)
    begin
        if (load_accept)
            work_reg <= cmd.value;
        else if (state_reg == ST_SPLIT)
            work_reg <= quot;

        if (emit_fire)
        begin
            seg_reg <= seg_of(store_reg[scan_pos_reg]);
            sel_reg <= blank_reg ? SEL_ALL_OFF : ~(8'd1 << sel_idx);
        end
    end

    assign disp.valid        = out_valid_reg;
    assign disp.segments     = seg_reg;
    assign disp.digit_select = sel_reg;

    `ASSERT_PROP(a_valid_from_emit, $rose(disp.valid) |-> $past(state_reg) == ST_EMIT, "result appeared without an emit step")
    `ASSERT_NEVER(a_idx_range, state_reg == ST_SPLIT && 4'(idx_reg) >= eff_cnt, "digit index ran past the count")
    `ASSERT_PROP(a_blank_one_tick, tick_accept && blank_reg |=> !blank_reg, "blanking lasted more than one tick")
    `ASSERT_PROP(a_load_keeps_scan, load_accept |=> $stable(scan_pos_reg) && $stable(blank_reg), "load disturbed the scan")

endmodule
